>>> sv/cmvg_pkg.sv
// ----------------------------------------------------------------------------
// cmvg_pkg: shared types and constants of the cone mesh vertex generator
// Widths, register indexes, divider lanes, CORDIC table and pipeline records.
// ----------------------------------------------------------------------------
package cmvg_pkg;

  localparam int DEF_MAX_SLICES = 256;
  localparam int DEF_MAX_STACKS = 256;

  localparam int CNT_W     = 9;   // slice and stack counts, ring index
  localparam int SLICE_W   = 8;
  localparam int LEN_W     = 15;  // radius and height, unsigned Q7.8
  localparam int COORD_W   = 16;  // signed Q7.8 coordinates
  localparam int TRIG_W    = 16;  // Q1.14 cos and sin
  localparam int DIV_W     = 26;  // dividend and partial remainder
  localparam int DEN_W     = 10;
  localparam int Q_W       = 16;
  localparam int DIV_STAGES = Q_W;
  localparam int NDIV      = 6;
  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_W  = 18;
  localparam int VCNT_W    = 3;

  // Divider lanes
  localparam int DIV_ANG0 = 0;
  localparam int DIV_ANG1 = 1;
  localparam int DIV_RLO  = 2;
  localparam int DIV_RHI  = 3;
  localparam int DIV_YLO  = 4;
  localparam int DIV_YHI  = 5;

  localparam logic [VCNT_W-1:0] VTX_LAST_BASE = 3'd2;
  localparam logic [VCNT_W-1:0] VTX_LAST_SIDE = 3'd5;

  localparam logic [LEN_W-1:0] RADIUS_RST = 15'd256;
  localparam logic [LEN_W-1:0] HEIGHT_RST = 15'd512;
  localparam logic [CNT_W-1:0] SLICES_RST = 9'd16;
  localparam logic [CNT_W-1:0] STACKS_RST = 9'd8;
  localparam logic [CNT_W-1:0] MIN_SLICES = 9'd3;
  localparam logic [CNT_W-1:0] MIN_STACKS = 9'd1;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 18'sd9949;
  localparam logic signed [CORDIC_W-1:0] ONE_Q14     = 18'sd16384;

  // Arctangent of 2^-i in units of 1/65536 turn
  localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
    18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1
  };

  typedef enum logic [1:0] {
    CFG_RADIUS,
    CFG_HEIGHT,
    CFG_SLICES,
    CFG_STACKS
  } cfg_idx_t;

  typedef struct packed {
    logic bad;
    logic ring0;
    logic neg_lo;
    logic neg_hi;
  } div_meta_t;

  typedef struct packed {
    logic                       bad;
    logic                       ring0;
    logic [LEN_W-1:0]           r_lo;
    logic [LEN_W-1:0]           r_hi;
    logic signed [COORD_W-1:0]  y_lo;
    logic signed [COORD_W-1:0]  y_hi;
  } req_t;

  typedef struct packed {
    req_t                      req;
    logic signed [TRIG_W-1:0]  c0;
    logic signed [TRIG_W-1:0]  s0;
    logic signed [TRIG_W-1:0]  c1;
    logic signed [TRIG_W-1:0]  s1;
  } hold_t;

endpackage

>>> sv/cmvg_if.sv
// ----------------------------------------------------------------------------
// cmvg_in_if / cmvg_out_if: request and vertex channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cmvg_in_if;
  import cmvg_pkg::*;
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   ring;
  logic [SLICE_W-1:0] slice;
  modport source (output valid, ring, slice, input ready);
  modport sink   (input valid, ring, slice, output ready);
endinterface

interface cmvg_out_if;
  import cmvg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vx;
  logic signed [COORD_W-1:0] vy;
  logic signed [COORD_W-1:0] vz;
  logic                      last_vertex;
  logic                      bad_index;
  modport source (output valid, vx, vy, vz, last_vertex, bad_index, input ready);
  modport sink   (input valid, vx, vy, vz, last_vertex, bad_index, output ready);
endinterface

>>> sv/cone_mesh_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// cone_mesh_vertex_generator_core: cone mesh patch to vertex stream
// Turns one (ring, slice) request into the vertices of its mesh patch.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   request words (ring, slice). Ring 0 gives the base triangle
//           (3 vertices), ring k gives side band k-1 (6 vertices), an index
//           beyond the configured counts gives one word with bad_index set.
//   out_if  vertex words; last_vertex marks the final word of a request.
//   cfg_*   register writes (radius, height, slice count, stack count),
//           taken on any edge with cfg_we high; write only while idle.
// Pipeline: 1 prep stage, 16 divider
//   stages (one quotient bit each), 1 angle stage, 14 CORDIC stages, then
//   the vertex hold register and the output register.
// Throughput: one request enters per cycle while the pipe has room; the
//   single output port drains 6 words per side band, 3 per base triangle,
//   1 per bad request, so the output port sets the sustained rate.
// Reset: synchronous, active low; clears all valid bits and loads the
//   register defaults (radius 1.0, height 2.0, 16 slices, 8 stacks).
// Stall: with out_if.ready low the output word holds; the pipe keeps
//   filling until its tail meets a full hold register, then in_if.ready
//   drops and every stage freezes in place.
// ----------------------------------------------------------------------------
module cone_mesh_vertex_generator_core #(
  parameter int MAX_SLICES = cmvg_pkg::DEF_MAX_SLICES,
  parameter int MAX_STACKS = cmvg_pkg::DEF_MAX_STACKS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  cmvg_pkg::cfg_idx_t           cfg_index,
  input  logic [cmvg_pkg::LEN_W-1:0]   cfg_wdata,
  cmvg_in_if.sink                      in_if,
  cmvg_out_if.source                   out_if
);
  import cmvg_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] radius_r, height_r;
  logic [CNT_W-1:0] slices_r, stacks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      height_r <= HEIGHT_RST;
      slices_r <= SLICES_RST;
      stacks_r <= STACKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        CFG_SLICES: slices_r <= cfg_wdata[CNT_W-1:0];
        CFG_STACKS: stacks_r <= cfg_wdata[CNT_W-1:0];
      endcase
    end
  end

  // Effective counts, clamped to the supported range
  logic [CNT_W-1:0] ns, nt;
  always_comb begin
    ns = slices_r;
    if (slices_r < MIN_SLICES) ns = MIN_SLICES;
    else if (32'(slices_r) > MAX_SLICES) ns = CNT_W'(MAX_SLICES);
    nt = stacks_r;
    if (stacks_r < MIN_STACKS) nt = MIN_STACKS;
    else if (32'(stacks_r) > MAX_STACKS) nt = CNT_W'(MAX_STACKS);
  end

  // --------------------------------------------------------------------------
  // Flow control: the whole pipe moves as one
  // --------------------------------------------------------------------------
  logic adv;
  logic hold_free;
  logic out_free;

  assign in_if.ready = adv;

  // --------------------------------------------------------------------------
  // Prep: angle indexes, level, dividends and divisors
  // --------------------------------------------------------------------------
  logic                ring_nz;
  logic                p_bad;
  logic [CNT_W-1:0]    lvl;
  logic [CNT_W-1:0]    m0, m1;
  logic [CNT_W-1:0]    span_lo, span_hi;
  logic signed [CNT_W+1:0] d_lo, d_hi;
  logic [CNT_W:0]      mag_lo, mag_hi;
  logic [DIV_W-1:0]    num [NDIV];
  logic [DEN_W-1:0]    den [NDIV];

  always_comb begin
    ring_nz = |in_if.ring;
    p_bad   = ({1'b0, in_if.slice} >= ns) || (in_if.ring > nt);
    lvl     = ring_nz ? in_if.ring - 1'b1 : '0;

    // Base uses angles slice, slice+1; side bands slice+1, slice+2 (mod ns)
    m0 = {1'b0, in_if.slice} + CNT_W'(ring_nz);
    if (m0 >= ns) m0 = m0 - ns;
    m1 = m0 + 1'b1;
    if (m1 == ns) m1 = '0;

    span_lo = nt - lvl;
    span_hi = nt - lvl - 1'b1;

    d_lo   = $signed({1'b0, lvl, 1'b0}) - $signed({2'b0, nt});
    d_hi   = d_lo + 11'sd2;
    mag_lo = d_lo[CNT_W+1] ? (CNT_W+1)'(-d_lo) : d_lo[CNT_W:0];
    mag_hi = d_hi[CNT_W+1] ? (CNT_W+1)'(-d_hi) : d_hi[CNT_W:0];

    num[DIV_ANG0] = DIV_W'({m0, 16'b0});
    num[DIV_ANG1] = DIV_W'({m1, 16'b0});
    num[DIV_RLO]  = DIV_W'(radius_r) * DIV_W'(span_lo);
    num[DIV_RHI]  = DIV_W'(radius_r) * DIV_W'(span_hi);
    // Floor of a negative quotient: negate the ceiling of the magnitude
    num[DIV_YLO]  = DIV_W'(height_r) * DIV_W'(mag_lo) +
                    (d_lo[CNT_W+1] ? DIV_W'({nt, 1'b0} - 1'b1) : '0);
    num[DIV_YHI]  = DIV_W'(height_r) * DIV_W'(mag_hi) +
                    (d_hi[CNT_W+1] ? DIV_W'({nt, 1'b0} - 1'b1) : '0);

    den[DIV_ANG0] = DEN_W'(ns);
    den[DIV_ANG1] = DEN_W'(ns);
    den[DIV_RLO]  = DEN_W'(nt);
    den[DIV_RHI]  = DEN_W'(nt);
    den[DIV_YLO]  = {nt, 1'b0};
    den[DIV_YHI]  = {nt, 1'b0};
  end

  // --------------------------------------------------------------------------
  // Divider pipeline: one restoring quotient bit per stage, six lanes
  // --------------------------------------------------------------------------
  logic             dv_r   [DIV_STAGES+1];
  div_meta_t        dm_r   [DIV_STAGES+1];
  logic [DIV_W-1:0] rem_r  [DIV_STAGES+1][NDIV];
  logic [DEN_W-1:0] den_r  [DIV_STAGES+1][NDIV];
  logic [Q_W-1:0]   q_r    [DIV_STAGES+1][NDIV];
  logic [DIV_W-1:0] rem_nxt [DIV_STAGES+1][NDIV];
  logic [Q_W-1:0]   q_nxt   [DIV_STAGES+1][NDIV];

  always_comb begin : div_step
    logic [DIV_W-1:0] sh;
    for (int d = 0; d < NDIV; d++) begin
      rem_nxt[0][d] = num[d];
      q_nxt[0][d]   = '0;
    end
    for (int s = 1; s <= DIV_STAGES; s++) begin
      for (int d = 0; d < NDIV; d++) begin
        sh = DIV_W'(den_r[s-1][d]) << (DIV_STAGES - s);
        if (rem_r[s-1][d] >= sh) begin
          rem_nxt[s][d] = rem_r[s-1][d] - sh;
          q_nxt[s][d]   = q_r[s-1][d] | (Q_W'(1) << (DIV_STAGES - s));
        end else begin
          rem_nxt[s][d] = rem_r[s-1][d];
          q_nxt[s][d]   = q_r[s-1][d];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dm_r[0] <= '{bad: p_bad, ring0: !ring_nz,
                   neg_lo: d_lo[CNT_W+1], neg_hi: d_hi[CNT_W+1]};
      for (int d = 0; d < NDIV; d++) begin
        den_r[0][d] <= den[d];
      end
      for (int s = 0; s <= DIV_STAGES; s++) begin
        for (int d = 0; d < NDIV; d++) begin
          rem_r[s][d] <= rem_nxt[s][d];
          q_r[s][d]   <= q_nxt[s][d];
        end
      end
      for (int s = 1; s <= DIV_STAGES; s++) begin
        dm_r[s] <= dm_r[s-1];
        for (int d = 0; d < NDIV; d++) begin
          den_r[s][d] <= den_r[s-1][d];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_STAGES; s++) dv_r[s] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= in_if.valid;
      for (int s = 1; s <= DIV_STAGES; s++) dv_r[s] <= dv_r[s-1];
    end
  end

  // --------------------------------------------------------------------------
  // Angle stage: fold phase into the right half plane, seed the CORDIC
  // --------------------------------------------------------------------------
  logic [Q_W-1:0] ph [2];
  logic           ph_flip [2];
  req_t           post_req;

  always_comb begin
    ph[0] = q_r[DIV_STAGES][DIV_ANG0];
    ph[1] = q_r[DIV_STAGES][DIV_ANG1];
    for (int a = 0; a < 2; a++) begin
      ph_flip[a] = ph[a][15] ^ ph[a][14];
    end
    post_req.bad   = dm_r[DIV_STAGES].bad;
    post_req.ring0 = dm_r[DIV_STAGES].ring0;
    post_req.r_lo  = q_r[DIV_STAGES][DIV_RLO][LEN_W-1:0];
    post_req.r_hi  = q_r[DIV_STAGES][DIV_RHI][LEN_W-1:0];
    post_req.y_lo  = dm_r[DIV_STAGES].neg_lo ? -$signed(q_r[DIV_STAGES][DIV_YLO])
                                              : $signed(q_r[DIV_STAGES][DIV_YLO]);
    post_req.y_hi  = dm_r[DIV_STAGES].neg_hi ? -$signed(q_r[DIV_STAGES][DIV_YHI])
                                              : $signed(q_r[DIV_STAGES][DIV_YHI]);
  end

  // --------------------------------------------------------------------------
  // CORDIC pipeline: one rotation per stage, two angles side by side
  // --------------------------------------------------------------------------
  logic                       cv_r   [CORDIC_STEPS+1];
  req_t                       creq_r [CORDIC_STEPS+1];
  logic                       cflip_r [CORDIC_STEPS+1][2];
  logic signed [CORDIC_W-1:0] cx_r   [CORDIC_STEPS+1][2];
  logic signed [CORDIC_W-1:0] cy_r   [CORDIC_STEPS+1][2];
  logic signed [CORDIC_W-1:0] cz_r   [CORDIC_STEPS+1][2];
  logic signed [CORDIC_W-1:0] cx_nxt [CORDIC_STEPS+1][2];
  logic signed [CORDIC_W-1:0] cy_nxt [CORDIC_STEPS+1][2];
  logic signed [CORDIC_W-1:0] cz_nxt [CORDIC_STEPS+1][2];

  always_comb begin : cordic_step
    logic signed [CORDIC_W-1:0] dx, dy;
    for (int a = 0; a < 2; a++) begin
      cx_nxt[0][a] = CORDIC_GAIN;
      cy_nxt[0][a] = '0;
      cz_nxt[0][a] = CORDIC_W'($signed({ph[a][15] ^ ph_flip[a], ph[a][14:0]}));
    end
    for (int i = 1; i <= CORDIC_STEPS; i++) begin
      for (int a = 0; a < 2; a++) begin
        dx = cy_r[i-1][a] >>> (i - 1);
        dy = cx_r[i-1][a] >>> (i - 1);
        if (!cz_r[i-1][a][CORDIC_W-1]) begin
          cx_nxt[i][a] = cx_r[i-1][a] - dx;
          cy_nxt[i][a] = cy_r[i-1][a] + dy;
          cz_nxt[i][a] = cz_r[i-1][a] - ATAN_TURNS[i-1];
        end else begin
          cx_nxt[i][a] = cx_r[i-1][a] + dx;
          cy_nxt[i][a] = cy_r[i-1][a] - dy;
          cz_nxt[i][a] = cz_r[i-1][a] + ATAN_TURNS[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      creq_r[0] <= post_req;
      for (int a = 0; a < 2; a++) cflip_r[0][a] <= ph_flip[a];
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
        for (int a = 0; a < 2; a++) begin
          cx_r[i][a] <= cx_nxt[i][a];
          cy_r[i][a] <= cy_nxt[i][a];
          cz_r[i][a] <= cz_nxt[i][a];
        end
      end
      for (int i = 1; i <= CORDIC_STEPS; i++) begin
        creq_r[i] <= creq_r[i-1];
        for (int a = 0; a < 2; a++) cflip_r[i][a] <= cflip_r[i-1][a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) cv_r[i] <= 1'b0;
    end else if (adv) begin
      cv_r[0] <= dv_r[DIV_STAGES];
      for (int i = 1; i <= CORDIC_STEPS; i++) cv_r[i] <= cv_r[i-1];
    end
  end

  // Undo the half-turn fold and clamp to [-1, 1]
  logic signed [CORDIC_W-1:0] fx [2];
  logic signed [CORDIC_W-1:0] fy [2];
  hold_t                      tail;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      fx[a] = cflip_r[CORDIC_STEPS][a] ? -cx_r[CORDIC_STEPS][a] : cx_r[CORDIC_STEPS][a];
      fy[a] = cflip_r[CORDIC_STEPS][a] ? -cy_r[CORDIC_STEPS][a] : cy_r[CORDIC_STEPS][a];
      if (fx[a] > ONE_Q14) fx[a] = ONE_Q14;
      else if (fx[a] < -ONE_Q14) fx[a] = -ONE_Q14;
      if (fy[a] > ONE_Q14) fy[a] = ONE_Q14;
      else if (fy[a] < -ONE_Q14) fy[a] = -ONE_Q14;
    end
    tail.req = creq_r[CORDIC_STEPS];
    tail.c0  = fx[0][TRIG_W-1:0];
    tail.s0  = fy[0][TRIG_W-1:0];
    tail.c1  = fx[1][TRIG_W-1:0];
    tail.s1  = fy[1][TRIG_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Vertex hold: one request, walked out while the output register is free, one vertex per cycle
  // --------------------------------------------------------------------------
  logic              hold_valid_r;
  logic [VCNT_W-1:0] vcnt_r;
  hold_t             hold_r;
  logic              emit;
  logic              hold_last;

  assign out_free  = !out_if.valid || out_if.ready;
  assign emit      = hold_valid_r && out_free;
  assign hold_last = hold_r.req.bad ||
                     (hold_r.req.ring0 ? (vcnt_r == VTX_LAST_BASE)
                                       : (vcnt_r == VTX_LAST_SIDE));
  assign hold_free = !hold_valid_r || (out_free && hold_last);
  assign adv       = !cv_r[CORDIC_STEPS] || hold_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      vcnt_r       <= '0;
    end else if (adv && cv_r[CORDIC_STEPS]) begin
      hold_valid_r <= 1'b1;
      vcnt_r       <= '0;
    end else if (emit && hold_last) begin
      hold_valid_r <= 1'b0;
    end else if (emit) begin
      vcnt_r <= vcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cv_r[CORDIC_STEPS]) hold_r <= tail;
  end

  // Vertex order. Base: rim a, centre, rim b.
  // Side band: lo a, lo b, hi a, lo b, hi b, hi a.
  logic                      sel_hi, sel_b, sel_zero;
  logic signed [LEN_W:0]     r_sel;
  logic signed [COORD_W-1:0] y_sel;
  logic signed [TRIG_W-1:0]  c_sel, s_sel;
  logic signed [31:0]        px, pz;
  logic signed [31:0]        sx, sz;
  logic signed [COORD_W-1:0] vx_nxt, vz_nxt;

  always_comb begin
    sel_hi   = 1'b0;
    sel_b    = 1'b0;
    sel_zero = 1'b0;
    if (hold_r.req.ring0) begin
      sel_zero = (vcnt_r == 3'd1);
      sel_b    = (vcnt_r == VTX_LAST_BASE);
    end else begin
      unique case (vcnt_r)
        3'd0:    begin sel_hi = 1'b0; sel_b = 1'b0; end
        3'd1:    begin sel_hi = 1'b0; sel_b = 1'b1; end
        3'd2:    begin sel_hi = 1'b1; sel_b = 1'b0; end
        3'd3:    begin sel_hi = 1'b0; sel_b = 1'b1; end
        3'd4:    begin sel_hi = 1'b1; sel_b = 1'b1; end
        default: begin sel_hi = 1'b1; sel_b = 1'b0; end
      endcase
    end
    r_sel = sel_zero ? '0 : $signed({1'b0, sel_hi ? hold_r.req.r_hi : hold_r.req.r_lo});
    y_sel = sel_hi ? hold_r.req.y_hi : hold_r.req.y_lo;
    c_sel = sel_b ? hold_r.c1 : hold_r.c0;
    s_sel = sel_b ? hold_r.s1 : hold_r.s0;

    // Scale by radius, round to nearest, saturate
    px = r_sel * s_sel;
    pz = r_sel * c_sel;
    sx = (px + 32'sd8192) >>> 14;
    sz = (pz + 32'sd8192) >>> 14;
    if (sx > 32'sd32767) vx_nxt = 16'sh7fff;
    else if (sx < -32'sd32768) vx_nxt = -16'sh8000;
    else vx_nxt = sx[COORD_W-1:0];
    if (sz > 32'sd32767) vz_nxt = 16'sh7fff;
    else if (sz < -32'sd32768) vz_nxt = -16'sh8000;
    else vz_nxt = sz[COORD_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_vx_r, out_vy_r, out_vz_r;
  logic                      out_last_r, out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_last_r <= hold_last;
      out_bad_r  <= hold_r.req.bad;
      if (hold_r.req.bad) begin
        out_vx_r <= '0;
        out_vy_r <= '0;
        out_vz_r <= '0;
      end else begin
        out_vx_r <= vx_nxt;
        out_vy_r <= y_sel;
        out_vz_r <= vz_nxt;
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.vx          = out_vx_r;
  assign out_if.vy          = out_vy_r;
  assign out_if.vz          = out_vz_r;
  assign out_if.last_vertex = out_last_r;
  assign out_if.bad_index   = out_bad_r;

endmodule

>>> bench/cmvg_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmvg_tb_if: bench-side helpers for the cone mesh vertex generator
// Holds the record type of one expected vertex word.
// ----------------------------------------------------------------------------
package cmvg_tb_pkg;
  import cmvg_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
    logic                      last_vertex;
    logic                      bad_index;
  } vertex_t;
endpackage

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the cone mesh vertex generator core
// Drives (ring, slice) request words from a directed table and then at
// random, predicts the vertex words of every accepted request and checks
// each output word in order. Both channels idle at random, the receiver
// holds off once for a long stretch and the sender drains before each register update.
// ----------------------------------------------------------------------------
module tb;
  import cmvg_pkg::*;
  import cmvg_tb_pkg::*;

  localparam int N_RANDOM   = 96;
  localparam int N_BURST    = 50;
  localparam int WDOG_LIMIT = 2000;
  localparam int DRAIN_WAIT = 60;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [LEN_W-1:0] cfg_wdata;

  cmvg_in_if  req_ch ();
  cmvg_out_if vtx_ch ();

  cone_mesh_vertex_generator_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_if(req_ch.sink), .out_if(vtx_ch.source)
  );

  // Bench copy of the registers
  int unsigned m_radius, m_height, m_slices, m_stacks;

  vertex_t vtx_queue[$];
  int  fail_count = 0;
  bit  rx_idle_on = 1;    // random receiver gaps enabled
  int  rx_hold = 0;       // cycles of forced receiver hold-off left
  int  wdog = 0;

  initial begin
    clk = 0;
  end
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Append one expected word at the tail
  function automatic void queue_word(vertex_t v);
    vtx_queue = {vtx_queue, v};
  endfunction

  // Rotation-mode CORDIC on a phase in 1/65536 turn, Q1.14 out
  function automatic void phase_trig(int unsigned t, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    x = 9949; y = 0; flip = 0;
    t &= 16'hFFFF;
    if (t >= 16384 && t < 49152) begin
      t = (t + 32768) & 16'hFFFF;
      flip = 1;
    end
    z = (t >= 32768) ? longint'(t) - 65536 : longint'(t);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURNS[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURNS[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(x, -16384, 16384);
    s = clip(y, -16384, 16384);
  endfunction

  function automatic vertex_t rim_vertex(longint r, longint y, int unsigned m,
                                         int unsigned ns, bit last);
    vertex_t v;
    longint c, s;
    int unsigned t;
    t = int'((longint'(m % ns) << 16) / ns);
    phase_trig(t, c, s);
    v.vx = COORD_W'(clip(floor_shr(r * s + 8192, 14), -32768, 32767));
    v.vy = COORD_W'(y);
    v.vz = COORD_W'(clip(floor_shr(r * c + 8192, 14), -32768, 32767));
    v.last_vertex = last;
    v.bad_index = 0;
    return v;
  endfunction

  task automatic predict_patch(int unsigned ring, int unsigned slice);
    int unsigned ns, nt, lvl;
    longint r_lo, r_hi, y_lo, y_hi;
    vertex_t v;
    ns = m_slices; nt = m_stacks;
    if (ns < 3) ns = 3;
    if (ns > 256) ns = 256;
    if (nt < 1) nt = 1;
    if (nt > 256) nt = 256;
    if (slice >= ns || ring > nt) begin
      v = '{0, 0, 0, 1, 1};
      queue_word(v);
      return;
    end
    if (ring == 0) begin
      y_lo = floor_div(-longint'(m_height) * nt, 2 * longint'(nt));
      queue_word(rim_vertex(m_radius, y_lo, slice, ns, 0));
      v = '{0, COORD_W'(y_lo), 0, 0, 0};
      queue_word(v);
      queue_word(rim_vertex(m_radius, y_lo, slice + 1, ns, 1));
      return;
    end
    lvl = ring - 1;
    r_lo = (longint'(m_radius) * (nt - lvl)) / nt;
    r_hi = (longint'(m_radius) * (nt - lvl - 1)) / nt;
    y_lo = floor_div(longint'(m_height) * (2 * longint'(lvl) - nt), 2 * longint'(nt));
    y_hi = floor_div(longint'(m_height) * (2 * longint'(lvl) + 2 - nt), 2 * longint'(nt));
    queue_word(rim_vertex(r_lo, y_lo, slice + 1, ns, 0));
    queue_word(rim_vertex(r_lo, y_lo, slice + 2, ns, 0));
    queue_word(rim_vertex(r_hi, y_hi, slice + 1, ns, 0));
    queue_word(rim_vertex(r_lo, y_lo, slice + 2, ns, 0));
    queue_word(rim_vertex(r_hi, y_hi, slice + 2, ns, 0));
    queue_word(rim_vertex(r_hi, y_hi, slice + 1, ns, 1));
  endtask

  // --------------------------------------------------------------------------
  // Register writes, only while the pipe is empty
  // --------------------------------------------------------------------------
  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[LEN_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_RADIUS: m_radius = val & 32'h7FFF;
      CFG_HEIGHT: m_height = val & 32'h7FFF;
      CFG_SLICES: m_slices = val & 32'h1FF;
      CFG_STACKS: m_stacks = val & 32'h1FF;
    endcase
  endtask

  // Drop the request, then wait for every expected word
  task automatic wait_drained();
    req_ch.valid <= 0;
    while (vtx_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_mesh(int unsigned r, int unsigned h, int unsigned ns,
                          int unsigned nt);
    wait_drained();
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_SLICES, ns);
    write_reg(CFG_STACKS, nt);
    cfg_we <= 0;
  endtask

  // --------------------------------------------------------------------------
  // Sender: offer one request word, hold it until taken; the next call
  // replaces it or drops valid, and the drain drops valid
  // --------------------------------------------------------------------------
  task automatic send_request(int unsigned ring, int unsigned slice, bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 20) begin
        req_ch.valid <= 0;
        @(posedge clk);
      end
    end
    req_ch.valid <= 1;
    req_ch.ring  <= ring[CNT_W-1:0];
    req_ch.slice <= slice[SLICE_W-1:0];
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_patch(ring, slice);
  endtask

  // Directed rows; a row with check set carries its one expected word
  typedef struct {
    int unsigned ring;
    int unsigned slice;
    bit          check;
    vertex_t     want;
  } stim_row_t;

  stim_row_t dir_rows[] = '{
    '{0,   0,   0, '{0, 0, 0, 0, 0}},   // base triangle at angle zero
    '{0,   15,  0, '{0, 0, 0, 0, 0}},   // base triangle wraps the turn
    '{1,   0,   0, '{0, 0, 0, 0, 0}},   // lowest side band
    '{8,   14,  0, '{0, 0, 0, 0, 0}},   // band at the apex, angle wraps
    '{8,   15,  0, '{0, 0, 0, 0, 0}},
    '{4,   7,   0, '{0, 0, 0, 0, 0}},
    '{9,   0,   1, '{0, 0, 0, 1, 1}},   // ring just past the stack count
    '{256, 0,   1, '{0, 0, 0, 1, 1}},
    '{0,   16,  1, '{0, 0, 0, 1, 1}},   // slice just past the slice count
    '{3,   255, 1, '{0, 0, 0, 1, 1}},
    '{511, 255, 1, '{0, 0, 0, 1, 1}}    // every index bit high
  };

  // --------------------------------------------------------------------------
  // Receiver: random ready, one forced long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      vtx_ch.ready <= 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      vtx_ch.ready <= 0;
    end else begin
      vtx_ch.ready <= !(rx_idle_on && $urandom_range(99) < 20);
    end
  end

  // Compare each accepted vertex word with the oldest expectation
  always @(posedge clk) begin
    vertex_t w;
    if (rst_n && vtx_ch.valid && vtx_ch.ready) begin
      if (vtx_queue.size() == 0) begin
        fail_count++;
        $display("%t unexpected vertex word vx=%0d vy=%0d vz=%0d", $realtime,
                 vtx_ch.vx, vtx_ch.vy, vtx_ch.vz);
      end else begin
        w = vtx_queue.pop_front();
        if (vtx_ch.vx !== w.vx || vtx_ch.vy !== w.vy || vtx_ch.vz !== w.vz ||
            vtx_ch.last_vertex !== w.last_vertex ||
            vtx_ch.bad_index !== w.bad_index) begin
          fail_count++;
          $display("%t mismatch expected %0d %0d %0d l%0b b%0b got %0d %0d %0d l%0b b%0b",
                   $realtime, w.vx, w.vy, w.vz, w.last_vertex, w.bad_index,
                   vtx_ch.vx, vtx_ch.vy, vtx_ch.vz, vtx_ch.last_vertex,
                   vtx_ch.bad_index);
        end
      end
    end
  end

  // Watchdog: restart on any handshake or when idle, give up after a long silence
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (vtx_ch.valid && vtx_ch.ready) ||
        (!req_ch.valid && vtx_queue.size() == 0)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned ns, nt, ring, slice, sel;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_RADIUS;
    cfg_wdata = '0;
    req_ch.valid = 0;
    req_ch.ring = '0;
    req_ch.slice = '0;
    m_radius = 256; m_height = 512; m_slices = 16; m_stacks = 8;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed rows at reset defaults; checked rows push their own word
    foreach (dir_rows[i]) begin
      if (dir_rows[i].check) begin
        send_request(dir_rows[i].ring, dir_rows[i].slice, 1);
        void'(vtx_queue.pop_back());
        queue_word(dir_rows[i].want);
      end else begin
        send_request(dir_rows[i].ring, dir_rows[i].slice, 1);
      end
    end

    // Extreme settings: counts below and above the clamp, largest lengths
    set_mesh(32767, 32767, 0, 0);
    send_request(0, 2, 1);
    send_request(1, 0, 1);
    send_request(2, 0, 1);
    send_request(0, 3, 1);
    set_mesh(0, 0, 511, 511);
    send_request(256, 255, 1);
    send_request(0, 255, 1);
    set_mesh(32767, 1, 256, 256);
    send_request(256, 255, 1);
    send_request(1, 128, 1);

    // Long receiver hold-off while the sender keeps offering
    wait_drained();
    rx_hold = 300;
    for (int i = 0; i < N_BURST; i++) begin
      send_request($urandom_range(256), $urandom_range(255), 0);
    end

    // Random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      ns = (ph == 0) ? 3 : $urandom_range(256, 3);
      nt = (ph == 1) ? 1 : $urandom_range(256, 1);
      if (ph == 5) begin
        ns = $urandom_range(511);
        nt = $urandom_range(511);
      end
      set_mesh($urandom_range(32767), $urandom_range(32767), ns, nt);
      rx_idle_on = (ph != 2);    // one stretch with no receiver gaps
      if (ns < 3) ns = 3;
      if (ns > 256) ns = 256;
      if (nt < 1) nt = 1;
      if (nt > 256) nt = 256;
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        sel = $urandom_range(99);
        if (sel < 85) begin
          ring  = $urandom_range(nt);
          slice = $urandom_range(ns - 1);
        end else begin
          ring  = $urandom_range(511);
          slice = $urandom_range(255);
        end
        send_request(ring, slice, ph != 2);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
